// ===== src/tcf_pkg.sv =====
`timescale 1ns / 1ps

package tcf_pkg;

	// Fixed field widths of the transactions and the serial divider.
	localparam int PERIOD_W = 20;
	localparam int TEMPO_W  = 16;
	localparam int MASTER_W = 16;
	localparam int ADDR_W   = 4;
	localparam int DIVD_W   = 17;
	localparam int DIVS_W   = 20;

	localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 20'hFFFFF;
	localparam logic [DIVD_W-1:0]   MS_PER_MINUTE = 17'd60000;
	localparam logic [PERIOD_W-1:0] RESET_PERIOD  = 20'd666;
	localparam logic [TEMPO_W-1:0]  RESET_TEMPO   = 16'd90;

	localparam logic [4:0]  RESET_FACTOR    = 5'd1;
	localparam logic [6:0]  RESET_STEP_LIM  = 7'd64;
	localparam logic [15:0] RESET_REFERENCE = 16'd666;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_BEAT = 1'b1;

	typedef enum logic [1:0] {
		CFG_DIVIDE_MODE = 2'd0,
		CFG_FACTOR      = 2'd1,
		CFG_STEP_LIMIT  = 2'd2,
		CFG_REFERENCE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PGO,
		ST_MUL,
		ST_PDIV,
		ST_TGO,
		ST_TDIV,
		ST_RGO,
		ST_RDIV,
		ST_WGO,
		ST_WDIV,
		ST_DONE
	} tcf_state_t;

	typedef struct packed {
		logic                operation;
		logic [MASTER_W-1:0] master_period_ms;
		logic [MASTER_W-1:0] master_step;
	} tcf_in_t;

	typedef struct packed {
		logic                fire;
		logic [PERIOD_W-1:0] fired_period_ms;
		logic [5:0]          step_count;
		logic [TEMPO_W-1:0]  tempo_bpm;
	} tcf_out_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} tcf_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
		logic [DIVS_W-1:0] remainder;
	} tcf_div_rsp_t;

endpackage

// ===== src/tcf_sdiv.sv =====
`timescale 1ns / 1ps

// Restoring divider that retires one quotient bit per cycle.
module tcf_sdiv
	import tcf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  tcf_div_req_t req,
	output tcf_div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] shift_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0]   trial;
	logic              qbit;

	assign trial = {rem_q, shift_q[DIVD_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			shift_q <= req.dividend;
			dvs_q   <= req.divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[DIVD_W-2:0], qbit};
			rem_q   <= qbit ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = shift_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== src/tempo_clock_follower_core.sv =====
`timescale 1ns / 1ps

// Slave step clock that follows a master beat. Each input transaction is either a
// one-millisecond tick or a master beat carrying the master period and step, and each
// one yields exactly one result transaction with the fire flag, the period when fired,
// the step counter and the tempo in beats per minute, unless a divide_mode or factor
// write cuts its job short. The block works on one transaction at a time; a new one
// is taken while the previous result still waits in the output register. Timing is
// set by one shared bit-serial divider and by a bit-serial multiplier of one factor
// bit per cycle. A tick without a self-fire needs no arithmetic unit; a tick that
// self-fires adds one division for the step wrap. A multiply-mode beat takes two
// divisions, or one when its period comes out as zero; a divide-mode beat takes the
// multiply plus two divisions. Writing divide_mode or factor recomputes the period
// and tempo from reference_period_ms, which keeps the input stalled until the
// recompute ends; the configuration port itself never waits.
module tempo_clock_follower_core
	import tcf_pkg::*;
#(
	parameter int MAX_STEPS  = 64,
	parameter int MAX_FACTOR = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  tcf_in_t           item,
	output logic              result_valid,
	input  logic              result_stall,
	output tcf_out_t          result
);

	// The factor register is five bits wide, so the effective factor never exceeds 31.
	localparam int FAC_CAP = (MAX_FACTOR > 31) ? 31 : MAX_FACTOR;
	localparam int EF_W    = $clog2(FAC_CAP + 1);
	// The step limit register is seven bits wide, so the effective limit stops at 127.
	localparam int LIM_CAP = (MAX_STEPS > 127) ? 127 : MAX_STEPS;
	localparam int SC_W    = $clog2(LIM_CAP);
	localparam int MUL_W   = MASTER_W + EF_W;

	function automatic logic [EF_W-1:0] eff_factor(input logic [4:0] raw);
		if (raw == '0) return EF_W'(1);
		else if (int'(raw) > FAC_CAP) return EF_W'(FAC_CAP);
		else return EF_W'(raw);
	endfunction

	// Configuration registers.
	logic        mode_q;
	logic [4:0]  factor_q;
	logic [6:0]  limit_q;
	logic [15:0] ref_q;

	// Clock state.
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] elapsed_q;
	logic [SC_W-1:0]     sc_q;
	logic [TEMPO_W-1:0]  tempo_q;

	// Job bookkeeping: a job is either a transaction or a configuration recompute.
	tcf_state_t          state_q, state_d, after_tempo;
	logic                cfg_job_q;
	logic                jmode_q;
	logic [EF_W-1:0]     ef_q;
	logic                fire_q;
	logic [MASTER_W-1:0] master_q;
	logic [MASTER_W-1:0] mstep_q;

	// Serial multiplier.
	logic [MUL_W-1:0] acc_q;
	logic [MUL_W-1:0] mcand_q;
	logic [EF_W-1:0]  mplier_q;
	logic [23:0]      acc_wide;
	logic [PERIOD_W-1:0] prod_sat;

	// Output register.
	logic     res_valid_q;
	tcf_out_t result_q;

	tcf_div_req_t div_req;
	tcf_div_rsp_t div_rsp;

	logic            cfg_wr;
	cfg_idx_t        cfg_idx;
	logic            recalc;
	logic            job_mode_d;
	logic [EF_W-1:0] job_ef_d;
	logic [EF_W-1:0] ef_now;
	logic [6:0]      lim_eff;
	logic            item_acc;
	logic            short_item;
	logic [PERIOD_W-1:0] el_inc;
	logic [7:0]      sc_inc;
	logic            self_fire;
	logic            out_free;

	tcf_sdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The port is always ready. A write of divide_mode or factor restarts the period
	// and tempo recompute with the new register value and the current reference.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = cfg_idx_t'(paddr[3:2]);
	assign recalc  = cfg_wr && (cfg_idx == CFG_DIVIDE_MODE || cfg_idx == CFG_FACTOR);

	assign job_mode_d = (cfg_idx == CFG_DIVIDE_MODE) ? pwdata[0] : mode_q;
	assign job_ef_d   = eff_factor((cfg_idx == CFG_FACTOR) ? pwdata[4:0] : factor_q);

	always_comb begin
		unique case (cfg_idx_t'(paddr[3:2]))
			CFG_DIVIDE_MODE: prdata = 32'(mode_q);
			CFG_FACTOR:      prdata = 32'(factor_q);
			CFG_STEP_LIMIT:  prdata = 32'(limit_q);
			CFG_REFERENCE:   prdata = 32'(ref_q);
			default:         prdata = '0;
		endcase
	end

	assign ef_now  = eff_factor(factor_q);
	assign lim_eff = (limit_q == '0) ? 7'd1 :
	                 (int'(limit_q) > LIM_CAP) ? 7'(LIM_CAP) : limit_q;

	// Input side. A new transaction is taken only when no job runs.
	assign item_stall = (state_q != ST_IDLE) || recalc;
	assign item_acc   = item_valid && !item_stall;

	// Ticks and beats with a zero master period only run the self-fire check, which
	// needs no arithmetic unit unless a self-fire wraps the step counter with a division.
	assign short_item = (item.operation == OP_TICK) || (item.master_period_ms == '0);
	assign el_inc     = (item.operation == OP_TICK && elapsed_q != PERIOD_MAX) ?
	                    elapsed_q + 1'b1 : elapsed_q;
	assign sc_inc     = 8'(sc_q) + 8'd1;
	assign self_fire  = !mode_q && (sc_inc < 8'(ef_now)) && (el_inc > period_q);

	assign acc_wide = 24'(acc_q);
	assign prod_sat = (acc_wide > 24'(PERIOD_MAX)) ? PERIOD_MAX : PERIOD_W'(acc_q);

	assign out_free = !res_valid_q || !result_stall;

	// After the tempo: a configuration job ends, a divide-mode beat still checks the
	// master step against the factor, and a multiply-mode beat fires at once.
	assign after_tempo = cfg_job_q ? ST_IDLE : (jmode_q ? ST_RGO : ST_DONE);

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					if (short_item) state_d = self_fire ? ST_WGO : ST_DONE;
					else state_d = ST_PGO;
				end
			end
			ST_PGO: begin
				if (jmode_q) begin
					state_d = ST_MUL;
				end else begin
					state_d          = ST_PDIV;
					div_req.start    = 1'b1;
					div_req.dividend = DIVD_W'(master_q);
					div_req.divisor  = DIVS_W'(ef_q);
				end
			end
			ST_MUL: begin
				if (mplier_q == '0) state_d = ST_TGO;
			end
			ST_PDIV: begin
				if (div_rsp.done) state_d = ST_TGO;
			end
			ST_TGO: begin
				if (period_q == '0) begin
					state_d = after_tempo;
				end else begin
					state_d          = ST_TDIV;
					div_req.start    = 1'b1;
					div_req.dividend = MS_PER_MINUTE;
					div_req.divisor  = period_q;
				end
			end
			ST_TDIV: begin
				if (div_rsp.done) state_d = after_tempo;
			end
			ST_RGO: begin
				state_d          = ST_RDIV;
				div_req.start    = 1'b1;
				div_req.dividend = DIVD_W'(mstep_q) + DIVD_W'(1);
				div_req.divisor  = DIVS_W'(ef_q);
			end
			ST_RDIV: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_WGO: begin
				state_d          = ST_WDIV;
				div_req.start    = 1'b1;
				div_req.dividend = DIVD_W'(sc_inc);
				div_req.divisor  = DIVS_W'(lim_eff);
			end
			ST_WDIV: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (recalc) state_d = ST_PGO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Registers, clock state and job control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			factor_q    <= RESET_FACTOR;
			limit_q     <= RESET_STEP_LIM;
			ref_q       <= RESET_REFERENCE;
			period_q    <= RESET_PERIOD;
			elapsed_q   <= '0;
			sc_q        <= '0;
			tempo_q     <= RESET_TEMPO;
			cfg_job_q   <= 1'b0;
			jmode_q     <= 1'b0;
			ef_q        <= EF_W'(1);
			fire_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					CFG_DIVIDE_MODE: mode_q   <= pwdata[0];
					CFG_FACTOR:      factor_q <= pwdata[4:0];
					CFG_STEP_LIMIT:  limit_q  <= pwdata[6:0];
					CFG_REFERENCE:   ref_q    <= pwdata[15:0];
					default:         ;
				endcase
			end

			if (recalc) begin
				cfg_job_q <= 1'b1;
				jmode_q   <= job_mode_d;
				ef_q      <= job_ef_d;
			end else if (item_acc) begin
				cfg_job_q <= 1'b0;
				jmode_q   <= mode_q;
				ef_q      <= ef_now;
				if (short_item) begin
					fire_q    <= self_fire;
					elapsed_q <= self_fire ? '0 : el_inc;
				end
			end

			case (state_q)
				ST_MUL: begin
					if (mplier_q == '0) period_q <= prod_sat;
				end
				ST_PDIV: begin
					if (div_rsp.done) period_q <= PERIOD_W'(div_rsp.quotient);
				end
				ST_TGO: begin
					if (period_q == '0) tempo_q <= '0;
				end
				ST_TDIV: begin
					if (div_rsp.done) tempo_q <= div_rsp.quotient[TEMPO_W-1:0];
				end
				ST_RDIV: begin
					if (div_rsp.done) begin
						fire_q <= (div_rsp.remainder == '0);
						if (div_rsp.remainder == '0) elapsed_q <= '0;
					end
				end
				ST_WDIV: begin
					if (div_rsp.done) sc_q <= SC_W'(div_rsp.remainder);
				end
				default: ;
			endcase

			// A multiply-mode beat always fires and restarts the counters.
			if (!recalc && state_d == ST_DONE &&
			    (state_q == ST_TGO || state_q == ST_TDIV)) begin
				fire_q    <= 1'b1;
				elapsed_q <= '0;
				sc_q      <= '0;
			end

			if (state_q == ST_DONE && out_free) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	// Operands and the shift-add multiplier, one factor bit per cycle.
	always_ff @(posedge clk) begin
		if (recalc) begin
			master_q <= ref_q;
		end else if (item_acc) begin
			master_q <= item.master_period_ms;
			mstep_q  <= item.master_step;
		end

		if (state_q == ST_PGO) begin
			acc_q    <= '0;
			mcand_q  <= MUL_W'(master_q);
			mplier_q <= ef_q;
		end else if (state_q == ST_MUL) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end

		if (state_q == ST_DONE && out_free) begin
			result_q.fire            <= fire_q;
			result_q.fired_period_ms <= fire_q ? period_q : '0;
			result_q.step_count      <= 6'(sc_q);
			result_q.tempo_bpm       <= tempo_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

	// A result only appears when a job has reached its final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done state");

	// A fired zero period must come with a zero tempo.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.fire && result.fired_period_ms == '0) |->
		(result.tempo_bpm == '0))
		else $error("zero period fired with nonzero tempo");

	// The tempo quotient can never exceed one minute in milliseconds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_rsp.done && state_q == ST_TDIV) |-> (div_rsp.quotient <= MS_PER_MINUTE))
		else $error("tempo quotient out of range");

endmodule

// ===== verif/tempo_clock_follower_core_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the tempo clock follower. Ticks and master beats go in on the
// item channel, one result transaction per item comes back, and every result is checked
// field by field against a behavioral model of the slave clock that lives in this file.
module tempo_clock_follower_core_test;
	import tcf_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int SLAVE_STEPS   = 64;
	localparam int SLAVE_FACTOR  = 16;
	localparam int unsigned MINUTE_MS  = 60000;
	localparam logic [PERIOD_W-1:0] PERIOD_CAP = 20'hFFFFF;

	// A write of divide_mode or factor makes the block recompute its period and tempo
	// with the serial arithmetic units, so the bench leaves it alone for a while.
	localparam int CFG_SETTLE      = 80;
	localparam int DRAIN_SETTLE    = 8;
	localparam int END_SETTLE      = 64;
	localparam int LONG_HOLD       = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_PHASES   = 14;
	localparam int ITEMS_PER_PHASE = 128;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            psel = 1'b0;
	logic            penable = 1'b0;
	logic            pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]     pwdata = '0;
	logic [31:0]     prdata;
	logic            pready;
	logic            item_valid = 1'b0;
	logic            item_stall;
	tcf_in_t         item = '0;
	logic            result_valid;
	logic            result_stall = 1'b0;
	tcf_out_t        result;

	// Configuration as the block should hold it, and the slave clock state it follows.
	logic                cfg_divide_mode;
	logic [4:0]          cfg_factor;
	logic [6:0]          cfg_step_limit;
	logic [15:0]         cfg_reference;
	logic [PERIOD_W-1:0] slave_period;
	logic [PERIOD_W-1:0] slave_elapsed;
	logic [5:0]          slave_steps;
	logic [TEMPO_W-1:0]  slave_tempo;

	tcf_in_t  pending_items [$];
	tcf_out_t expected_steps [$];
	tcf_out_t want_step;

	int items_queued = 0;
	int items_taken  = 0;
	int mismatches   = 0;
	int idle_cycles  = 0;

	// Handshake bookkeeping shared between the clocked processes.
	logic item_took   = 1'b0;
	logic result_took = 1'b0;
	int   in_idle_max  = 0;
	int   out_idle_max = 0;
	int   send_gap     = 0;
	int   stall_left   = 0;
	int   hold_left    = 0;
	int   hold_requests = 0;
	int   hold_served   = 0;

	// Register settings that the first random phases are guaranteed to visit, so that
	// zero and out-of-range values are exercised next to the legal extremes.
	int unsigned factor_picks [8] = '{0, 1, 2, 3, 5, 16, 17, 31};
	int unsigned limit_picks [8]  = '{64, 1, 127, 0, 2, 65, 7, 64};

	tempo_clock_follower_core #(
		.MAX_STEPS (SLAVE_STEPS),
		.MAX_FACTOR(SLAVE_FACTOR)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------------
	// Slave clock model
	// ------------------------------------------------------------------------------

	// A factor of zero behaves as one and anything above the maximum saturates.
	function automatic int unsigned factor_eff();
		if (cfg_factor == 0) return 1;
		if (cfg_factor > SLAVE_FACTOR) return SLAVE_FACTOR;
		return cfg_factor;
	endfunction

	function automatic int unsigned step_limit_eff();
		if (cfg_step_limit == 0) return 1;
		if (cfg_step_limit > SLAVE_STEPS) return SLAVE_STEPS;
		return cfg_step_limit;
	endfunction

	// The period saturates at the 20-bit maximum; a zero period gives a zero tempo.
	function automatic void store_period(longint unsigned p);
		slave_period = (p > PERIOD_CAP) ? PERIOD_CAP : p[PERIOD_W-1:0];
		slave_tempo  = (slave_period == 0) ? '0 : TEMPO_W'(MINUTE_MS / slave_period);
	endfunction

	function automatic void derive_period(int unsigned master);
		if (cfg_divide_mode)
			store_period(longint'(master) * factor_eff());
		else
			store_period(master / factor_eff());
	endfunction

	// In multiply mode the slave steps on its own between beats once the elapsed time
	// passes its period, but only while the step count plus one is below the factor.
	function automatic bit catch_up_fire();
		if (cfg_divide_mode) return 1'b0;
		if (slave_steps + 1 >= factor_eff()) return 1'b0;
		if (slave_elapsed <= slave_period) return 1'b0;
		slave_elapsed = '0;
		slave_steps = 6'((slave_steps + 1) % step_limit_eff());
		return 1'b1;
	endfunction

	function automatic tcf_out_t next_slave_step(tcf_in_t it);
		tcf_out_t r;
		bit fired;
		fired = 1'b0;
		if (it.operation == OP_TICK) begin
			if (slave_elapsed != PERIOD_CAP) slave_elapsed++;
			fired = catch_up_fire();
		end else if (it.master_period_ms == 0) begin
			// A beat without a period only runs the catch-up check.
			fired = catch_up_fire();
		end else if (cfg_divide_mode) begin
			derive_period(it.master_period_ms);
			if ((32'(it.master_step) + 1) % factor_eff() == 0) begin
				slave_elapsed = '0;
				fired = 1'b1;
			end
		end else begin
			derive_period(it.master_period_ms);
			slave_elapsed = '0;
			slave_steps = '0;
			fired = 1'b1;
		end
		r.fire = fired;
		r.fired_period_ms = fired ? slave_period : '0;
		r.step_count = slave_steps;
		r.tempo_bpm = slave_tempo;
		return r;
	endfunction

	// Mode and factor writes recompute the period from the reference period right away;
	// step limit and reference writes only store the value.
	function automatic void apply_register_write(cfg_idx_t idx, logic [31:0] value);
		case (idx)
			CFG_DIVIDE_MODE: begin
				cfg_divide_mode = value[0];
				derive_period(cfg_reference);
			end
			CFG_FACTOR: begin
				cfg_factor = value[4:0];
				derive_period(cfg_reference);
			end
			CFG_STEP_LIMIT: cfg_step_limit = value[6:0];
			CFG_REFERENCE:  cfg_reference = value[15:0];
		endcase
	endfunction

	initial begin
		cfg_divide_mode = 1'b0;
		cfg_factor      = RESET_FACTOR;
		cfg_step_limit  = RESET_STEP_LIM;
		cfg_reference   = RESET_REFERENCE;
		slave_period    = 20'd666;
		slave_elapsed   = '0;
		slave_steps     = '0;
		slave_tempo     = 16'd90;
	end

	// ------------------------------------------------------------------------------
	// Driver: presents queued transactions at the falling edge, with a random gap
	// after each one. A presented transaction is held until the block takes it.
	// ------------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_took) begin
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
				send_gap = $urandom_range(0, in_idle_max);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: after each result it draws a number of stall cycles. A long hold-off,
	// when requested, keeps the output stalled so the block has to back up its input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = LONG_HOLD - 1;
			result_stall <= 1'b1;
		end else begin
			if (result_took) stall_left = $urandom_range(0, out_idle_max);
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------------------
	// Monitor: at each rising edge, an accepted input transaction is run through the
	// model and an accepted result is compared with the oldest prediction. The input
	// side goes first so a result can never overtake its own prediction.
	// ------------------------------------------------------------------------------
	always @(posedge clk) begin
		item_took   <= item_valid && !item_stall;
		result_took <= result_valid && !result_stall;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				expected_steps.push_back(next_slave_step(item));
				items_taken++;
			end
			if (result_valid && !result_stall) begin
				if (expected_steps.size() == 0) begin
					$display("%0t: result %h arrived with nothing expected", $time, result);
					mismatches++;
				end else begin
					want_step = expected_steps.pop_front();
					check_field("fire", want_step.fire, result.fire);
					check_field("fired_period_ms", want_step.fired_period_ms,
						result.fired_period_ms);
					check_field("step_count", want_step.step_count, result.step_count);
					check_field("tempo_bpm", want_step.tempo_bpm, result.tempo_bpm);
				end
			end
			// The watchdog restarts on any transaction on either channel or the register port.
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(psel && penable && pwrite)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------------

	task automatic queue_item(logic op, logic [15:0] master, logic [15:0] mstep);
		tcf_in_t t;
		t.operation = op;
		t.master_period_ms = master;
		t.master_step = mstep;
		pending_items.push_back(t);
		items_queued++;
	endtask

	// Waits until every queued transaction was taken and every result came back.
	task automatic wait_until_drained();
		do @(negedge clk);
		while (items_taken != items_queued || expected_steps.size() != 0);
		repeat (DRAIN_SETTLE) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the data at the
	// rising edge of the access cycle since pready is always high.
	task automatic write_register(cfg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		apply_register_write(idx, value);
		repeat (CFG_SETTLE) @(negedge clk);
	endtask

	// Reconfigures an idle block. The reference goes first so that the mode and factor
	// writes derive the period from it. Returns at a rising edge, ready for queuing.
	task automatic configure_phase(logic mode, logic [4:0] factor, logic [6:0] limit,
		logic [15:0] reference, int in_max, int out_max, bit long_hold);
		wait_until_drained();
		write_register(CFG_REFERENCE, reference);
		write_register(CFG_STEP_LIMIT, limit);
		write_register(CFG_DIVIDE_MODE, mode);
		write_register(CFG_FACTOR, factor);
		// Sometimes change the reference afterwards; that must not move the period.
		if ($urandom_range(0, 1)) write_register(CFG_REFERENCE, $urandom());
		@(posedge clk);
		in_idle_max = in_max;
		out_idle_max = out_max;
		if (long_hold) hold_requests++;
	endtask

	// Mostly well-formed traffic: in multiply mode a beat whose period is short enough
	// that the following run of ticks triggers the catch-up steps, in divide mode beats
	// with a running master step counter and a few ticks between them. The rest is
	// random beats, beats without a period and loose ticks.
	task automatic queue_phase_items(int count);
		int n;
		int unsigned f;
		int unsigned per;
		int ticks;
		int pick;
		logic [15:0] master_step_run;
		n = 0;
		f = factor_eff();
		master_step_run = $urandom();
		while (n < count) begin
			pick = $urandom_range(0, 9);
			if (pick < 7 && !cfg_divide_mode) begin
				per = $urandom_range(0, 10);
				queue_item(OP_BEAT, per * f + $urandom_range(0, f - 1), $urandom());
				ticks = $urandom_range(0, (per + 2) * f + 2);
				repeat (ticks) queue_item(OP_TICK, $urandom(), $urandom());
				n += ticks + 1;
			end else if (pick < 7) begin
				queue_item(OP_BEAT, $urandom_range(1, 3000), master_step_run);
				master_step_run++;
				ticks = $urandom_range(0, 4);
				repeat (ticks) queue_item(OP_TICK, $urandom(), $urandom());
				n += ticks + 1;
			end else if (pick == 7) begin
				queue_item(OP_BEAT, $urandom(), $urandom());
				n++;
			end else if (pick == 8) begin
				queue_item(OP_BEAT, 16'd0, $urandom());
				n++;
			end else begin
				ticks = $urandom_range(1, 6);
				repeat (ticks) queue_item(OP_TICK, $urandom(), $urandom());
				n += ticks;
			end
		end
	endtask

	// ------------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------------
	initial begin
		int p;
		int in_max;
		int out_max;
		bit mode_pick;
		int unsigned factor_pick;
		int unsigned limit_pick;
		int unsigned ref_pick;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings, multiply by one: a tick, a beat without a period, the largest
		// master period (tempo rounds down to zero), the smallest one (full tempo), then
		// ticks that pass the period but may not step on their own with factor one.
		@(posedge clk);
		in_idle_max = 3;
		out_idle_max = 3;
		queue_item(OP_TICK, 16'hFFFF, 16'hFFFF);
		queue_item(OP_BEAT, 16'd0, 16'd0);
		queue_item(OP_BEAT, 16'hFFFF, 16'hFFFF);
		queue_item(OP_BEAT, 16'd1, 16'd0);
		queue_item(OP_TICK, 16'd0, 16'd0);
		queue_item(OP_TICK, 16'd0, 16'd0);

		// Multiply by four from a zero reference: the period becomes zero, so every tick
		// steps with a zero fired period and the counter wraps at a step limit of three.
		// A beat shorter than the factor also gives a zero period.
		configure_phase(1'b0, 5'd4, 7'd3, 16'd0, 0, 5, 1'b0);
		repeat (4) queue_item(OP_TICK, 16'd0, 16'd0);
		queue_item(OP_BEAT, 16'd3, 16'd7);
		queue_item(OP_BEAT, 16'd0, 16'd0);
		queue_item(OP_TICK, 16'd0, 16'd0);

		// Divide by sixteen at the largest periods: the product nearly fills the 20-bit
		// period. The master step wraps from all ones, and a step that is not a
		// multiple of the factor must not fire; a beat without a period does nothing.
		configure_phase(1'b1, 5'd16, 7'd1, 16'hFFFF, 5, 0, 1'b0);
		queue_item(OP_BEAT, 16'hFFFF, 16'd15);
		queue_item(OP_BEAT, 16'hFFFF, 16'hFFFF);
		queue_item(OP_BEAT, 16'd100, 16'd0);
		queue_item(OP_BEAT, 16'd0, 16'd15);
		queue_item(OP_TICK, 16'd0, 16'd0);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 8) begin
				mode_pick = p[0];
				factor_pick = factor_picks[p];
				limit_pick = limit_picks[p];
			end else begin
				mode_pick = $urandom_range(0, 1);
				factor_pick = $urandom_range(0, 31);
				limit_pick = $urandom_range(0, 127);
			end
			ref_pick = (p % 4 == 3) ? $urandom_range(0, 65535) : $urandom_range(1, 300);

			// Phases two and five run without idling on either side; phase two also gets
			// the long receiver hold-off while the driver keeps offering transactions.
			if (p == 2 || p == 5) begin
				in_max = 0;
				out_max = 0;
			end else begin
				in_max = (p % 3 == 1) ? 0 : 16;
				out_max = (p % 3 == 0) ? 0 : 16;
			end
			configure_phase(mode_pick, factor_pick, limit_pick, ref_pick, in_max, out_max,
				p == 2);

			if (p == 4) begin
				// The driver runs dry half way and waits for the block to empty out
				// before it continues.
				queue_phase_items(ITEMS_PER_PHASE / 2);
				wait_until_drained();
				@(posedge clk);
				queue_phase_items(ITEMS_PER_PHASE / 2);
			end else begin
				queue_phase_items(ITEMS_PER_PHASE);
			end
		end

		wait_until_drained();
		repeat (END_SETTLE) @(negedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
